// ===== src/brst_pkg.sv =====
// Shared types and constants for the bitmap rank/select tree.
// Request and response beat layouts; no dependencies.
`timescale 1ns / 1ps

package brst_pkg;

  localparam int POS_W  = 10;
  localparam int RANK_W = 11;

  localparam logic MODE_SET    = 1'b0;
  localparam logic MODE_SELECT = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [POS_W-1:0]  position;
    logic              bit_value;
    logic [RANK_W-1:0] rank_index;
  } req_t;

  typedef struct packed {
    logic [POS_W-1:0]  selected_position;
    logic              found;
    logic [RANK_W-1:0] total_count;
  } rsp_t;

endpackage

// ===== src/brst_mem.sv =====
// Node count store: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module brst_mem #(
  parameter int AW = 11,
  parameter int DW = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] ram [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      ram[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= ram[raddr];
  end

endmodule

// ===== src/brst_ctrl.sv =====
// Sequencer for the rank/select tree: clear sweep, leaf-to-root update,
// root-to-leaf descent and the response register. Uses brst_pkg.
`timescale 1ns / 1ps

module brst_ctrl #(
  parameter int LEAVES = 1024,
  parameter int AW     = 11,
  parameter int CW     = 11
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  brst_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output brst_pkg::rsp_t rsp,
  output logic           we,
  output logic [AW-1:0]  waddr,
  output logic [CW-1:0]  wdata,
  output logic [AW-1:0]  raddr,
  input  logic [CW-1:0]  rdata
);

  import brst_pkg::*;

  localparam int LW    = AW - 1;
  localparam int SPAN  = 1 << LW;
  localparam int CMP_W = ((CW > RANK_W) ? CW : RANK_W) + 1;

  typedef enum logic [4:0] {
    CLEAR = 5'b00001,
    IDLE  = 5'b00010,
    UP    = 5'b00100,
    SEL   = 5'b01000,
    HOLD  = 5'b10000
  } state_t;

  state_t            state;
  logic [AW-1:0]     clr;
  logic [AW-1:0]     node;
  logic [CW-1:0]     cur;
  logic [CW-1:0]     acc;
  logic [CW-1:0]     total;
  logic [RANK_W-1:0] k;
  rsp_t              hold_rsp;

  logic [AW-1:0] leaf;
  logic          pos_ok;
  logic          k_ok;
  logic [CW-1:0] up_sum;
  logic [AW-1:0] up_parent;
  logic          go_left;
  logic [AW-1:0] sel_next;
  logic          sel_leaf;
  logic          fin;
  rsp_t          fin_rsp;
  logic          rsp_free;
  logic          rsp_load;

  assign req_ready = (state == IDLE);
  assign rsp_free  = !rsp_valid || rsp_ready;
  assign rsp_load  = rsp_free && (fin || state == HOLD);

  assign leaf      = AW'(SPAN) + AW'(req.position);
  assign pos_ok    = 32'(req.position) < 32'(LEAVES);
  assign k_ok      = (req.rank_index != '0) && (CMP_W'(req.rank_index) <= CMP_W'(total));
  assign up_sum    = CW'(cur + rdata);
  assign up_parent = node >> 1;
  assign go_left   = (CMP_W'(acc) + CMP_W'(rdata)) >= CMP_W'(k);
  assign sel_next  = {node[AW-2:0], ~go_left};
  assign sel_leaf  = sel_next[AW-1];

  always_comb begin
    we      = 1'b0;
    waddr   = clr;
    wdata   = '0;
    raddr   = node;
    fin     = 1'b0;
    fin_rsp = '0;
    case (state)
      CLEAR: begin
        we = 1'b1;
      end
      IDLE: begin
        if (req_valid) begin
          if (req.mode == MODE_SET && pos_ok) begin
            we    = 1'b1;
            waddr = leaf;
            wdata = CW'(req.bit_value);
            raddr = leaf ^ AW'(1);
          end else if (req.mode == MODE_SELECT && k_ok) begin
            raddr = AW'(2);
          end else begin
            fin                 = 1'b1;
            fin_rsp.total_count = RANK_W'(total);
          end
        end
      end
      UP: begin
        we    = 1'b1;
        waddr = up_parent;
        wdata = up_sum;
        if (up_parent == AW'(1)) begin
          fin                 = 1'b1;
          fin_rsp.total_count = RANK_W'(up_sum);
        end else begin
          raddr = up_parent ^ AW'(1);
        end
      end
      SEL: begin
        if (sel_leaf) begin
          fin                       = 1'b1;
          fin_rsp.selected_position = POS_W'(sel_next[LW-1:0]);
          fin_rsp.found             = 1'b1;
          fin_rsp.total_count       = RANK_W'(total);
        end else begin
          raddr = {sel_next[AW-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CLEAR;
      clr       <= '0;
      total     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_ready && !rsp_load) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        CLEAR: begin
          clr <= clr + AW'(1);
          if (&clr) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (req_valid) begin
            if (req.mode == MODE_SET && pos_ok) begin
              node  <= leaf;
              cur   <= CW'(req.bit_value);
              state <= UP;
            end else if (req.mode == MODE_SELECT && k_ok) begin
              node  <= AW'(1);
              acc   <= '0;
              k     <= req.rank_index;
              state <= SEL;
            end
          end
        end
        UP: begin
          node <= up_parent;
          cur  <= up_sum;
          if (up_parent == AW'(1)) begin
            total <= up_sum;
          end
        end
        SEL: begin
          if (!go_left) begin
            acc <= CW'(acc + rdata);
          end
          node <= sel_next;
        end
        HOLD: begin
          if (rsp_free) begin
            rsp       <= hold_rsp;
            rsp_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
      if (fin) begin
        if (rsp_free) begin
          rsp       <= fin_rsp;
          rsp_valid <= 1'b1;
          state     <= IDLE;
        end else begin
          hold_rsp <= fin_rsp;
          state    <= HOLD;
        end
      end
    end
  end

  // Update walk never reaches the root node as its current node.
  a_up_below_root: assert property (@(posedge clk) disable iff (rst)
    (state == UP) |-> (node > AW'(1)))
    else $error("update walk at root");

  // Descent only runs for a rank inside 1..total.
  a_sel_rank: assert property (@(posedge clk) disable iff (rst)
    (state == SEL) |-> (k != '0 && CMP_W'(k) <= CMP_W'(total)))
    else $error("descent with out-of-range rank");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    32'(total) <= 32'(LEAVES))
    else $error("total exceeds leaf count");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (fin && !rsp_free) |=> (state == HOLD))
    else $error("finished result lost on stall");

endmodule

// ===== src/bitmap_rank_select_tree_top.sv =====
// Top level of the bitmap rank/select tree: sequencer plus node count store.
// Depends on brst_pkg, brst_mem and brst_ctrl.
//
//   channel | handshake             | beat
//   req     | req_valid / req_ready | brst_pkg::req_t
//   rsp     | rsp_valid / rsp_ready | brst_pkg::rsp_t
//
// One item at a time. A set or a select walks one tree level per cycle on the
// single write/read port pair, a set from leaf to root and a select from root to
// leaf; an ignored set or an out-of-range select is answered from the idle state.
// After reset a clearing sweep writes 2 * LEAVES (rounded to a power of two)
// entries, one per cycle, with req_ready low.
// A result waiting on rsp_ready stalls the next item at its last step.
`timescale 1ns / 1ps

module bitmap_rank_select_tree_top #(
  parameter int LEAVES = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  brst_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output brst_pkg::rsp_t rsp
);

  import brst_pkg::*;

  localparam int LW = $clog2(LEAVES);
  localparam int AW = LW + 1;
  localparam int CW = $clog2(LEAVES + 1);

  logic          we;
  logic [AW-1:0] waddr;
  logic [CW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [CW-1:0] rdata;

  brst_ctrl #(
    .LEAVES (LEAVES),
    .AW     (AW),
    .CW     (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  brst_mem #(
    .AW (AW),
    .DW (CW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule
